// ----- design/stb_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the timer bank
package stb_pkg;

    // default bank size, report limit and fixed field widths
    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_REPORTS   = 16;
    localparam int OP_W          = 2;
    localparam int SLOT_W        = 4;
    localparam int STATUS_W      = 2;
    localparam int TIME_W        = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_RUN = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the incoming transaction
        logic exec;        // perform start or stop
        logic alloc_step;  // test one slot for allocate
        logic tick_inc;    // advance time, issue first slot read
        logic scan_step;   // evaluate one slot, issue next read
        logic flush;       // emit the final tick result
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic alloc_done;  // allocate found a slot or ran out
        logic scan_done;   // last slot is being evaluated
    } t_stat;

endpackage

// ----- design/software_timer_bank.sv -----
// top level of the timer bank: controller plus datapath
//
// Usage: pulse i_start with i_operation, i_slot and i_period while o_busy is
// low; that edge accepts the transaction. Operations are allocate (lowest
// free slot), start (load period, deadline = now + period), stop, and tick
// (advance time by one, then fire every due running slot in ascending order).
// Each result appears for exactly one cycle with o_valid high; o_last marks
// the final result of a transaction. The receiver cannot stall the block.
// Start and stop pass through the EXEC state, whose result is registered;
// the block is busy only in that state. Allocate walks the slots one per
// cycle and stops at the first free slot or at the last one. A tick is busy
// through the TICK state, which advances time and issues the first slot
// read, then SCAN, with one slot evaluated per cycle through the deadline
// memory read port, and FLUSH, which emits the final result. All fire
// results but the last come out while the scan runs, at most one per cycle.
// Reset (synchronous, active low) frees every slot and clears time to zero;
// period and deadline storage needs no clearing since it is only read for
// running slots, which are always written by start first.
module software_timer_bank #(
    parameter int NUM_SLOTS = stb_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [stb_pkg::OP_W-1:0]        i_operation,
    input  logic [stb_pkg::SLOT_W-1:0]      i_slot,
    input  logic [stb_pkg::TIME_W-1:0]      i_period,
    output logic                            o_valid,
    output logic [stb_pkg::STATUS_W-1:0]    o_status,
    output logic [stb_pkg::SLOT_W-1:0]      o_slot_index,
    output logic                            o_fired,
    output logic                            o_last,
    output logic [stb_pkg::TIME_W-1:0]      o_time_now
);

    stb_pkg::t_cmd  cmd;
    stb_pkg::t_stat stat;

    // sequencer
    stb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    // slot storage and result generation
    stb_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_operation  (i_operation),
        .i_slot       (i_slot),
        .i_period     (i_period),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_fired      (o_fired),
        .o_last       (o_last),
        .o_time_now   (o_time_now)
    );

endmodule

// ----- design/stb_ctrl.sv -----
// sequencing state machine of the timer bank
module stb_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [stb_pkg::OP_W-1:0]        i_operation,
    input  stb_pkg::t_stat                  i_stat,
    output stb_pkg::t_cmd                   o_cmd,
    output logic                            o_busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_ALLOC = 6'b000100,
        S_TICK  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_operation == stb_pkg::OP_ALLOC) begin
                        n_state = S_ALLOC;
                    end else if (i_operation == stb_pkg::OP_TICK) begin
                        n_state = S_TICK;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            S_ALLOC: begin
                o_cmd.alloc_step = 1'b1;
                if (i_stat.alloc_done) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                o_cmd.tick_inc = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- design/stb_datapath.sv -----
// slot state, period/deadline memories, tick counter and result registers
module stb_datapath #(
    parameter int NUM_SLOTS = stb_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  stb_pkg::t_cmd                   i_cmd,
    output stb_pkg::t_stat                  o_stat,
    input  logic [stb_pkg::OP_W-1:0]        i_operation,
    input  logic [stb_pkg::SLOT_W-1:0]      i_slot,
    input  logic [stb_pkg::TIME_W-1:0]      i_period,
    output logic                            o_valid,
    output logic [stb_pkg::STATUS_W-1:0]    o_status,
    output logic [stb_pkg::SLOT_W-1:0]      o_slot_index,
    output logic                            o_fired,
    output logic                            o_last,
    output logic [stb_pkg::TIME_W-1:0]      o_time_now
);

    localparam int SLOT_W   = stb_pkg::SLOT_W;
    localparam int TIME_W   = stb_pkg::TIME_W;
    localparam int OP_W     = stb_pkg::OP_W;
    localparam int STATUS_W = stb_pkg::STATUS_W;
    localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS + 1) : 1;
    localparam int REP_W    = $clog2(stb_pkg::MAX_REPORTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [REP_W-1:0] REP_MAX  = REP_W'(stb_pkg::MAX_REPORTS);

    // captured transaction
    logic [OP_W-1:0]        r_op,     n_op;
    logic [SLOT_W-1:0]      r_slot,   n_slot;
    logic [TIME_W-1:0]      r_period, n_period;

    // bank state
    logic [TIME_W-1:0]      r_tick,      n_tick;
    logic [NUM_SLOTS-1:0]   r_allocated, n_allocated;
    logic [NUM_SLOTS-1:0]   r_running,   n_running;

    // period and deadline stores, only read behind a running bit
    logic [TIME_W-1:0]      mem_period   [NUM_SLOTS];
    logic [TIME_W-1:0]      mem_deadline [NUM_SLOTS];
    logic [TIME_W-1:0]      r_rd_period;
    logic [TIME_W-1:0]      r_rd_deadline;

    // scan bookkeeping
    logic [CNT_W-1:0]       r_idx,      n_idx;
    logic [IDX_W-1:0]       r_ev_idx,   n_ev_idx;
    logic                   r_pend_v,   n_pend_v;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic [REP_W-1:0]       r_nrep,     n_nrep;

    // result registers
    logic                   r_o_valid,  n_o_valid;
    logic [STATUS_W-1:0]    r_o_status, n_o_status;
    logic [SLOT_W-1:0]      r_o_slot,   n_o_slot;
    logic                   r_o_fired,  n_o_fired;
    logic                   r_o_last,   n_o_last;
    logic [TIME_W-1:0]      r_o_time,   n_o_time;

    // memory write controls
    logic                   dl_we;
    logic [IDX_W-1:0]       dl_waddr;
    logic [TIME_W-1:0]      dl_wdata;
    logic                   per_we;

    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       slot_idx;
    logic                   slot_ok;
    logic                   rd_en;
    logic                   ev_fire;

    assign idx      = r_idx[IDX_W-1:0];
    assign slot_idx = IDX_W'(r_slot);
    assign slot_ok  = (32'(r_slot) < 32'(NUM_SLOTS));
    assign rd_en    = (32'(r_idx) < 32'(NUM_SLOTS));
    assign ev_fire  = r_running[r_ev_idx] && (r_tick >= r_rd_deadline);

    assign o_stat.alloc_done = !r_allocated[idx] || (idx == LAST_IDX);
    assign o_stat.scan_done  = (r_ev_idx == LAST_IDX);

    // next-state logic for all operations
    always_comb begin
        n_op        = r_op;
        n_slot      = r_slot;
        n_period    = r_period;
        n_tick      = r_tick;
        n_allocated = r_allocated;
        n_running   = r_running;
        n_idx       = r_idx;
        n_ev_idx    = r_ev_idx;
        n_pend_v    = r_pend_v;
        n_pend_idx  = r_pend_idx;
        n_nrep      = r_nrep;
        n_o_valid   = 1'b0;
        n_o_status  = r_o_status;
        n_o_slot    = r_o_slot;
        n_o_fired   = r_o_fired;
        n_o_last    = r_o_last;
        n_o_time    = r_o_time;
        dl_we       = 1'b0;
        dl_waddr    = slot_idx;
        dl_wdata    = r_tick + r_period;
        per_we      = 1'b0;

        // capture the transaction and reset scan state
        if (i_cmd.load) begin
            n_op     = i_operation;
            n_slot   = i_slot;
            n_period = i_period;
            n_idx    = '0;
            n_pend_v = 1'b0;
            n_nrep   = '0;
        end

        // start or stop of a given slot
        if (i_cmd.exec) begin
            n_o_valid = 1'b1;
            n_o_slot  = r_slot;
            n_o_fired = 1'b0;
            n_o_last  = 1'b1;
            n_o_time  = r_tick;
            if (r_op == stb_pkg::OP_START) begin
                if (slot_ok) begin
                    dl_we                 = 1'b1;
                    per_we                = 1'b1;
                    n_allocated[slot_idx] = 1'b1;
                    n_running[slot_idx]   = 1'b1;
                    n_o_status            = stb_pkg::ST_OK;
                end else begin
                    n_o_status = stb_pkg::ST_NOT_RUN;
                end
            end else begin
                if (slot_ok && r_running[slot_idx]) begin
                    n_allocated[slot_idx] = 1'b0;
                    n_running[slot_idx]   = 1'b0;
                    n_o_status            = stb_pkg::ST_OK;
                end else begin
                    n_o_status = stb_pkg::ST_NOT_RUN;
                end
            end
        end

        // allocate: walk up from slot 0 to the first free one
        if (i_cmd.alloc_step) begin
            if (!r_allocated[idx]) begin
                n_allocated[idx] = 1'b1;
                n_running[idx]   = 1'b0;
                n_o_valid        = 1'b1;
                n_o_status       = stb_pkg::ST_OK;
                n_o_slot         = SLOT_W'(idx);
                n_o_fired        = 1'b0;
                n_o_last         = 1'b1;
                n_o_time         = r_tick;
            end else if (idx == LAST_IDX) begin
                n_o_valid  = 1'b1;
                n_o_status = stb_pkg::ST_NO_FREE;
                n_o_slot   = '0;
                n_o_fired  = 1'b0;
                n_o_last   = 1'b1;
                n_o_time   = r_tick;
            end else begin
                n_idx = r_idx + CNT_W'(1);
            end
        end

        // tick: advance time and issue the read of slot 0
        if (i_cmd.tick_inc) begin
            n_tick   = r_tick + TIME_W'(1);
            n_ev_idx = idx;
            n_idx    = r_idx + CNT_W'(1);
        end

        // scan: evaluate the slot read last cycle, read the next one
        if (i_cmd.scan_step) begin
            n_ev_idx = idx;
            if (rd_en) begin
                n_idx = r_idx + CNT_W'(1);
            end
            if (ev_fire) begin
                if (r_rd_period != '0) begin
                    dl_we    = 1'b1;
                    dl_waddr = r_ev_idx;
                    dl_wdata = r_tick + r_rd_period;
                end else begin
                    n_allocated[r_ev_idx] = 1'b0;
                    n_running[r_ev_idx]   = 1'b0;
                end
                // hold one report back so the final one can carry last
                if (r_nrep < REP_MAX) begin
                    if (r_pend_v) begin
                        n_o_valid  = 1'b1;
                        n_o_status = stb_pkg::ST_OK;
                        n_o_slot   = SLOT_W'(r_pend_idx);
                        n_o_fired  = 1'b1;
                        n_o_last   = 1'b0;
                        n_o_time   = r_tick;
                    end
                    n_pend_v   = 1'b1;
                    n_pend_idx = r_ev_idx;
                    n_nrep     = r_nrep + REP_W'(1);
                end
            end
        end

        // end of tick: last fired slot, or a plain no-fire result
        if (i_cmd.flush) begin
            n_o_valid  = 1'b1;
            n_o_status = stb_pkg::ST_OK;
            n_o_last   = 1'b1;
            n_o_time   = r_tick;
            n_pend_v   = 1'b0;
            if (r_pend_v) begin
                n_o_slot  = SLOT_W'(r_pend_idx);
                n_o_fired = 1'b1;
            end else begin
                n_o_slot  = '0;
                n_o_fired = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_allocated <= '0;
            r_running   <= '0;
            r_idx       <= '0;
            r_pend_v    <= 1'b0;
            r_nrep      <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_tick      <= n_tick;
            r_allocated <= n_allocated;
            r_running   <= n_running;
            r_idx       <= n_idx;
            r_pend_v    <= n_pend_v;
            r_nrep      <= n_nrep;
            r_o_valid   <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_slot     <= n_slot;
        r_period   <= n_period;
        r_ev_idx   <= n_ev_idx;
        r_pend_idx <= n_pend_idx;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_fired  <= n_o_fired;
        r_o_last   <= n_o_last;
        r_o_time   <= n_o_time;
    end

    // period and deadline memories, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            mem_deadline[dl_waddr] <= dl_wdata;
        end
        if (per_we) begin
            mem_period[slot_idx] <= r_period;
        end
        if (rd_en) begin
            r_rd_deadline <= mem_deadline[idx];
            r_rd_period   <= mem_period[idx];
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_slot_index = r_o_slot;
    assign o_fired      = r_o_fired;
    assign o_last       = r_o_last;
    assign o_time_now   = r_o_time;

    // a running slot is always allocated
    a_run_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running & ~r_allocated) == '0)
        else $error("running slot without allocation");

    // time only moves by one, and only on a tick command
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_tick != $past(r_tick))) |->
        ($past(i_cmd.tick_inc) && (r_tick == $past(r_tick) + TIME_W'(1))))
        else $error("tick counter moved unexpectedly");

    // a held report has been counted
    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_nrep != '0) && (r_nrep <= REP_MAX))
        else $error("pending report not counted");

    // the flush result always closes the tick transaction
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_o_valid && r_o_last))
        else $error("tick transaction ended without last result");

endmodule

// ----- dv/software_timer_bank_tb.sv -----
// self-checking testbench for the timer bank: directed and random commands, scoreboard checks
`timescale 1ns / 100ps

module software_timer_bank_tb;

    localparam int NUM_SLOTS   = stb_pkg::NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 2 * NUM_SLOTS + 8;
    localparam int RANDOM_CMDS = 300;
    localparam int STATUS_W    = stb_pkg::STATUS_W;
    localparam int SLOT_W      = stb_pkg::SLOT_W;
    localparam int TIME_W      = stb_pkg::TIME_W;
    localparam int OP_W        = stb_pkg::OP_W;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic                fired;
        logic                last;
        logic [TIME_W-1:0]   time_now;
    } t_timer_result;

    // timer bank predictor plus queue of results still owed by the block
    class t_timer_bank_checker;
        t_timer_result     owed_results[$];
        int unsigned       failures;
        bit                allocated[NUM_SLOTS];
        bit                running[NUM_SLOTS];
        logic [TIME_W-1:0] reload_period[NUM_SLOTS];
        logic [TIME_W-1:0] deadline[NUM_SLOTS];
        logic [TIME_W-1:0] tick_count;

        function new();
            failures   = 0;
            tick_count = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                allocated[i]     = 1'b0;
                running[i]       = 1'b0;
                reload_period[i] = '0;
                deadline[i]      = '0;
            end
        endfunction

        function t_timer_result build(logic [STATUS_W-1:0] status, int idx, bit fired,
                                      bit last);
            t_timer_result r;
            r.status     = status;
            r.slot_index = idx[SLOT_W-1:0];
            r.fired      = fired;
            r.last       = last;
            r.time_now   = tick_count;
            return r;
        endfunction

        // update the predicted state for an accepted command and queue its results
        function void note_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                   logic [TIME_W-1:0] period);
            int            n;
            bit            found;
            t_timer_result held;
            n     = 0;
            found = 1'b0;
            case (op)
                stb_pkg::OP_ALLOC: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!found && !allocated[i]) begin
                            found            = 1'b1;
                            allocated[i]     = 1'b1;
                            running[i]       = 1'b0;
                            reload_period[i] = '0;
                            deadline[i]      = '0;
                            owed_results.push_back(build(stb_pkg::ST_OK, i, 1'b0, 1'b1));
                        end
                    end
                    if (!found)
                        owed_results.push_back(build(stb_pkg::ST_NO_FREE, 0, 1'b0, 1'b1));
                end
                stb_pkg::OP_START: begin
                    if (int'(slot) >= NUM_SLOTS) begin
                        owed_results.push_back(build(stb_pkg::ST_NOT_RUN, int'(slot), 1'b0,
                                                     1'b1));
                    end else begin
                        reload_period[slot] = period;
                        deadline[slot]      = tick_count + period;
                        allocated[slot]     = 1'b1;
                        running[slot]       = 1'b1;
                        owed_results.push_back(build(stb_pkg::ST_OK, int'(slot), 1'b0, 1'b1));
                    end
                end
                stb_pkg::OP_STOP: begin
                    if (int'(slot) >= NUM_SLOTS || !running[slot]) begin
                        owed_results.push_back(build(stb_pkg::ST_NOT_RUN, int'(slot), 1'b0,
                                                     1'b1));
                    end else begin
                        running[slot]   = 1'b0;
                        allocated[slot] = 1'b0;
                        owed_results.push_back(build(stb_pkg::ST_OK, int'(slot), 1'b0, 1'b1));
                    end
                end
                default: begin
                    // tick: advance time, then fire due slots lowest first
                    tick_count = tick_count + TIME_W'(1);
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (running[i] && tick_count >= deadline[i]) begin
                            if (n < stb_pkg::MAX_REPORTS) begin
                                if (n > 0) owed_results.push_back(held);
                                held = build(stb_pkg::ST_OK, i, 1'b1, 1'b0);
                                n++;
                            end
                            if (reload_period[i] != '0) begin
                                deadline[i] = tick_count + reload_period[i];
                            end else begin
                                running[i]   = 1'b0;
                                allocated[i] = 1'b0;
                            end
                        end
                    end
                    if (n == 0) begin
                        owed_results.push_back(build(stb_pkg::ST_OK, 0, 1'b0, 1'b1));
                    end else begin
                        held.last = 1'b1;
                        owed_results.push_back(held);
                    end
                end
            endcase
        endfunction

        function void flag(string what, logic [TIME_W-1:0] exp_val, logic [TIME_W-1:0] act_val);
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected %0h, got %0h", what, exp_val, act_val);
        endfunction

        // compare one result transaction against the oldest owed result
        function void check_result(t_timer_result act);
            t_timer_result exp;
            if (owed_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: slot %0d time %0d", act.slot_index,
                             act.time_now);
                return;
            end
            exp = owed_results.pop_front();
            if (act.status !== exp.status)
                flag("status", TIME_W'(exp.status), TIME_W'(act.status));
            if (act.slot_index !== exp.slot_index)
                flag("slot_index", TIME_W'(exp.slot_index), TIME_W'(act.slot_index));
            if (act.fired !== exp.fired)
                flag("fired", TIME_W'(exp.fired), TIME_W'(act.fired));
            if (act.last !== exp.last)
                flag("last", TIME_W'(exp.last), TIME_W'(act.last));
            if (act.time_now !== exp.time_now) flag("time_now", exp.time_now, act.time_now);
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_start     = 1'b0;
    logic [OP_W-1:0]     i_operation = stb_pkg::OP_ALLOC;
    logic [SLOT_W-1:0]   i_slot      = '0;
    logic [TIME_W-1:0]   i_period    = '0;
    logic                o_busy;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_index;
    logic                o_fired;
    logic                o_last;
    logic [TIME_W-1:0]   o_time_now;

    t_timer_bank_checker sb;
    int                  idle_pct = 0;
    int                  cycles   = 0;

    software_timer_bank #(.NUM_SLOTS(NUM_SLOTS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_operation  (i_operation),
        .i_slot       (i_slot),
        .i_period     (i_period),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_fired      (o_fired),
        .o_last       (o_last),
        .o_time_now   (o_time_now)
    );

    always #4 i_clk = ~i_clk;

    // monitor: check results first, then record the accepted command
    always @(posedge i_clk) begin
        t_timer_result act;
        if (i_rst_n) begin
            if (o_valid) begin
                act.status     = o_status;
                act.slot_index = o_slot_index;
                act.fired      = o_fired;
                act.last       = o_last;
                act.time_now   = o_time_now;
                sb.check_result(act);
            end
            if (i_start && !o_busy) sb.note_command(i_operation, i_slot, i_period);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // present one command transaction and hold it until the block takes it
    task automatic drive_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                 logic [TIME_W-1:0] period);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start     <= 1'b1;
        i_operation <= op;
        i_slot      <= slot;
        i_period    <= period;
        do @(posedge i_clk); while (o_busy);
    endtask

    function automatic logic [TIME_W-1:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(5, 0);
        if (r < 75) return $urandom();
        if (r < 90) return 32'hFFFF_FFFF - $urandom_range(8, 0);
        return $urandom_range(40, 6);
    endfunction

    initial begin
        int sent;
        int r;
        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tick, idle stop, fill the bank, one-shot, periodic, wrapped deadline
        drive_command(stb_pkg::OP_TICK, 4'd0, '0);
        drive_command(stb_pkg::OP_STOP, 4'd3, '0);
        repeat (NUM_SLOTS) drive_command(stb_pkg::OP_ALLOC, 4'($urandom_range(15)), $urandom());
        drive_command(stb_pkg::OP_ALLOC, 4'd15, 32'hFFFF_FFFF);
        drive_command(stb_pkg::OP_START, 4'd0, 32'd0);
        drive_command(stb_pkg::OP_START, 4'd15, 32'd2);
        drive_command(stb_pkg::OP_START, 4'd7, 32'hFFFF_FFFF);
        repeat (3) drive_command(stb_pkg::OP_TICK, 4'd15, 32'hFFFF_FFFF);
        drive_command(stb_pkg::OP_STOP, 4'd7, '0);
        drive_command(stb_pkg::OP_STOP, 4'd15, '0);
        drive_command(stb_pkg::OP_STOP, 4'd15, '0);
        drive_command(stb_pkg::OP_STOP, 4'd5, '0);

        // random: weighted command mix with occasional bursts that arm every slot
        sent = 0;
        while (sent < RANDOM_CMDS) begin
            case (sent * 4 / RANDOM_CMDS)
                0:       idle_pct = 0;
                1:       idle_pct = 48;
                2:       idle_pct = 15;
                default: idle_pct = 0;
            endcase
            r = $urandom_range(99);
            if (r < 4) begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    drive_command(stb_pkg::OP_START, 4'(i), $urandom_range(2, 0));
                sent += NUM_SLOTS;
            end else begin
                if (r < 38)
                    drive_command(stb_pkg::OP_TICK, 4'($urandom_range(15)), $urandom());
                else if (r < 68)
                    drive_command(stb_pkg::OP_START, 4'($urandom_range(15)), pick_period());
                else if (r < 86)
                    drive_command(stb_pkg::OP_STOP, 4'($urandom_range(15)), $urandom());
                else
                    drive_command(stb_pkg::OP_ALLOC, 4'($urandom_range(15)), $urandom());
                sent++;
            end
        end
        @(negedge i_clk);
        i_start <= 1'b0;

        // drain
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.outstanding() != 0) $display("%0d results never arrived", sb.outstanding());
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
